// ===== rtl/core/kti_pkg.sv =====
package kti_pkg;

  // fixed field widths
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned DELTA_W   = 20;
  localparam int unsigned KIDX_W    = 6;
  localparam int unsigned KCNT_W    = 7;
  localparam int unsigned ENTRY_W   = TIME_W + 3 * VAL_W;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DIV_STEPS = TIME_W + FRAC_BITS;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic REG_KEY_COUNT   = 1'b0;
  localparam logic REG_LOOP_ENABLE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_RLAST, S_LAST, S_K0, S_SCAN, S_FB,
    S_DIVINIT, S_DIV, S_FIX, S_MUL, S_ACC, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_LAST, RD_ZERO, RD_ONE, RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    tick_start;
    logic    load_wr;
    rd_sel_t rd_sel;
    logic    cap_last;
    logic    cap_k0;
    logic    scan_step;
    logic    fallback;
    logic    div_init;
    logic    div_step;
    logic    fix_f;
    logic    mul;
    logic    acc;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic single;
    logic match;
    logic scan_end;
    logic den_zero;
    logic div_last;
    logic axis_last;
  } status_t;

endpackage

// ===== rtl/core/kti_ctrl.sv =====
module kti_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tuser,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  kti_pkg::status_t st,
  output kti_pkg::cmd_t    cmd
);
  import kti_pkg::*;

  state_t state, state_next;
  logic   m_tvalid_next;
  logic   accept;
  logic   out_free;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // state register and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && s_tuser) state_next = S_RLAST;
      end
      S_RLAST: state_next = S_LAST;
      S_LAST: begin
        state_next = st.single ? S_DONE : S_K0;
      end
      S_K0: state_next = S_SCAN;
      S_SCAN: begin
        if (st.match) begin
          state_next = S_DIVINIT;
        end else if (st.scan_end) begin
          state_next = S_FB;
        end
      end
      S_FB: state_next = S_DIVINIT;
      S_DIVINIT: begin
        state_next = st.den_zero ? S_FIX : S_DIV;
      end
      S_DIV: begin
        if (st.div_last) state_next = S_FIX;
      end
      S_FIX: state_next = S_MUL;
      S_MUL: state_next = S_ACC;
      S_ACC: begin
        state_next = st.axis_last ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    s_tready = (state == S_IDLE);
    cmd      = '0;
    cmd.rd_sel = RD_NEXT;
    case (state)
      S_IDLE: begin
        cmd.tick_start = accept && s_tuser;
        cmd.load_wr    = accept && !s_tuser;
      end
      S_RLAST: cmd.rd_sel = RD_LAST;
      S_LAST: begin
        cmd.cap_last = 1'b1;
        cmd.rd_sel   = RD_ZERO;
      end
      S_K0: begin
        cmd.cap_k0 = 1'b1;
        cmd.rd_sel = RD_ONE;
      end
      S_SCAN:    cmd.scan_step = 1'b1;
      S_FB:      cmd.fallback  = 1'b1;
      S_DIVINIT: cmd.div_init  = 1'b1;
      S_DIV:     cmd.div_step  = 1'b1;
      S_FIX:     cmd.fix_f     = 1'b1;
      S_MUL:     cmd.mul       = 1'b1;
      S_ACC:     cmd.acc       = 1'b1;
      S_DONE:    cmd.out_load  = out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/kti_dp.sv =====
module kti_dp #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [kti_pkg::KCNT_W-1:0]        cfg_data,
  input  logic [kti_pkg::KIDX_W-1:0]        key_index,
  input  logic [kti_pkg::TIME_W-1:0]        key_time,
  input  logic [kti_pkg::VAL_W-1:0]         key_x,
  input  logic [kti_pkg::VAL_W-1:0]         key_y,
  input  logic [kti_pkg::VAL_W-1:0]         key_z,
  input  logic [kti_pkg::DELTA_W-1:0]       tick_delta,
  input  kti_pkg::cmd_t                     cmd,
  output kti_pkg::status_t                  st,
  output logic [kti_pkg::VAL_W-1:0]         pos_x,
  output logic [kti_pkg::VAL_W-1:0]         pos_y,
  output logic [kti_pkg::VAL_W-1:0]         pos_z,
  output logic [kti_pkg::TIME_W-1:0]        track_time
);
  import kti_pkg::*;

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  // configuration and track state
  logic [KCNT_W-1:0] key_count;
  logic              loop_enable;
  logic [TIME_W-1:0] elapsed;

  // keyframe store: time in the low word, then x, y, z
  logic [ENTRY_W-1:0] mem [MAX_KEYS];
  logic [ENTRY_W-1:0] rdata;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [31:0]        kidx_ext;
  logic               w_ok;

  // per-tick working registers
  logic [TIME_W-1:0]  t;
  logic [CW-1:0]      n;
  logic               single;
  logic [TIME_W-1:0]  last_time;
  logic [AW-1:0]      idx;
  logic [ENTRY_W-1:0] cur, k0, k1, sreg, ereg;
  logic [47:0]        dvd;
  logic [TIME_W-1:0]  dvs, rem;
  logic               q_neg;
  logic [DCNT_W-1:0]  dcnt;
  logic signed [31:0] f;
  logic [1:0]         axis;
  logic signed [64:0] prod;
  logic [VAL_W-1:0]   res [3];

  // combinational helpers
  logic [31:0]        n32;
  logic [32:0]        tsum;
  logic [TIME_W-1:0]  t_new;
  logic [32:0]        num33, den33;
  logic [31:0]        num_abs, den_abs;
  logic [32:0]        rem_sh;
  logic               qbit;
  logic signed [31:0] a_s, b_s;
  logic signed [32:0] d_s;
  logic signed [64:0] adj;
  logic signed [64:0] qv;
  logic signed [65:0] v;
  logic [TIME_W-1:0]  elapsed_new;

  assign n32      = (32'(key_count) > MAX_KEYS) ? MAX_KEYS : 32'(key_count);
  assign tsum     = {1'b0, elapsed} + 33'(tick_delta);
  assign t_new    = tsum[32] ? '1 : tsum[TIME_W-1:0];
  assign kidx_ext = 32'(key_index);
  assign waddr    = kidx_ext[AW-1:0];
  assign w_ok     = kidx_ext < MAX_KEYS;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count   <= KCNT_W'(1);
      loop_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_COUNT:   key_count   <= cfg_data;
        REG_LOOP_ENABLE: loop_enable <= cfg_data[0];
        default: begin
          key_count <= key_count;
        end
      endcase
    end
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_LAST: raddr = single ? '0 : AW'(32'(n) - 32'd1);
      RD_ZERO: raddr = '0;
      RD_ONE:  raddr = AW'(1);
      RD_NEXT: raddr = idx + AW'(1);
      default: raddr = '0;
    endcase
  end

  // keyframe memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_wr && w_ok) begin
      mem[waddr] <= {key_z, key_y, key_x, key_time};
    end
    rdata <= mem[raddr];
  end

  // bracket test on the pair (cur, rdata)
  assign st.single   = single;
  assign st.match    = (cur[TIME_W-1:0] <= t) && (t <= rdata[TIME_W-1:0]);
  assign st.scan_end = (CW'(idx) == n - CW'(1));
  assign st.den_zero = (sreg[TIME_W-1:0] == ereg[TIME_W-1:0]);
  assign st.div_last = (dcnt == DCNT_W'(DIV_STEPS - 1));
  assign st.axis_last = (axis == 2'd2);

  // fraction operands
  assign num33   = {1'b0, t} - {1'b0, sreg[TIME_W-1:0]};
  assign den33   = {1'b0, ereg[TIME_W-1:0]} - {1'b0, sreg[TIME_W-1:0]};
  assign num_abs = num33[32] ? 32'(-num33) : num33[31:0];
  assign den_abs = den33[32] ? 32'(-den33) : den33[31:0];

  // one restoring divide step
  assign rem_sh = {rem, dvd[47]};
  assign qbit   = rem_sh >= {1'b0, dvs};

  // blend of one axis
  assign a_s = sreg[VAL_W + VAL_W * axis +: VAL_W];
  assign b_s = ereg[VAL_W + VAL_W * axis +: VAL_W];
  assign d_s = 33'(b_s) - 33'(a_s);
  assign adj = prod + (prod[64] ? 65'sd65535 : 65'sd0);
  assign qv  = adj >>> FRAC_BITS;
  assign v   = 66'(a_s) + 66'(qv);

  assign elapsed_new = (loop_enable && (t > last_time)) ? '0 : t;

  // tick sequence registers
  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      t      <= t_new;
      n      <= CW'(n32);
      single <= n32 < 32'd2;
    end
    if (cmd.cap_last) begin
      last_time <= rdata[TIME_W-1:0];
      res[0]    <= rdata[TIME_W +: VAL_W];
      res[1]    <= rdata[TIME_W + VAL_W +: VAL_W];
      res[2]    <= rdata[TIME_W + 2 * VAL_W +: VAL_W];
    end
    if (cmd.cap_k0) begin
      cur <= rdata;
      k0  <= rdata;
      idx <= AW'(1);
    end
    if (cmd.scan_step) begin
      if (idx == AW'(1)) k1 <= rdata;
      if (st.match) begin
        sreg <= cur;
        ereg <= rdata;
      end else begin
        cur <= rdata;
        idx <= idx + AW'(1);
      end
    end
    if (cmd.fallback) begin
      sreg <= k0;
      ereg <= k1;
    end
    if (cmd.div_init) begin
      dvd   <= {num_abs, 16'd0};
      dvs   <= den_abs;
      rem   <= '0;
      q_neg <= num33[32] ^ den33[32];
      dcnt  <= '0;
    end
    if (cmd.div_step) begin
      rem  <= qbit ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      dvd  <= {dvd[46:0], qbit};
      dcnt <= dcnt + DCNT_W'(1);
    end
    if (cmd.fix_f) begin
      axis <= '0;
      if (st.den_zero) begin
        f <= '0;
      end else if (q_neg) begin
        f <= (dvd > 48'h8000_0000) ? 32'sh8000_0000 : 32'(48'd0 - dvd);
      end else begin
        f <= (dvd > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dvd[31:0];
      end
    end
    if (cmd.mul) begin
      prod <= d_s * f;
    end
    if (cmd.acc) begin
      if (v > 66'sh7FFF_FFFF) begin
        res[axis] <= 32'h7FFF_FFFF;
      end else if (v < -66'sh8000_0000) begin
        res[axis] <= 32'h8000_0000;
      end else begin
        res[axis] <= v[31:0];
      end
      axis <= axis + 2'd1;
    end
    if (cmd.out_load) begin
      pos_x      <= res[0];
      pos_y      <= res[1];
      pos_z      <= res[2];
      track_time <= single ? elapsed : elapsed_new;
    end
  end

  // track time
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (cmd.out_load && !single) begin
      elapsed <= elapsed_new;
    end
  end

endmodule

// ===== rtl/core/keyframe_track_interpolator.sv =====
// Linear keyframe interpolator for a three-axis track in Q16.16. Load
// transactions (tuser low) write one keyframe; the block is ready again at
// the next edge. A tick transaction (tuser high) advances the track time by
// its delta, scans the keys one per cycle for the first bracketing pair
// (keys 0 and 1 extrapolate if none brackets), divides for the fraction
// with a one-bit-per-cycle 48-step divider, and blends x, y and z through
// one shared multiplier. The length of a tick is set by the key scan over
// the single memory read port and by the divider; with fewer than two keys
// it skips both. Results wait in an output register, so the next
// transaction is taken while a result is still pending.
module keyframe_track_interpolator #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [6:0]   cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // key_index, key_time, key_x, key_y, key_z, tick_delta, zero pad
  input  logic [159:0] s_tdata,
  // req_type
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, pos_z, track_time
  output logic [127:0] m_tdata
);
  import kti_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic [VAL_W-1:0]  pos_x, pos_y, pos_z;
  logic [TIME_W-1:0] track_time;

  kti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  kti_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .key_index  (s_tdata[5:0]),
    .key_time   (s_tdata[37:6]),
    .key_x      (s_tdata[69:38]),
    .key_y      (s_tdata[101:70]),
    .key_z      (s_tdata[133:102]),
    .tick_delta (s_tdata[153:134]),
    .cmd        (cmd),
    .st         (st),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .track_time (track_time)
  );

  assign m_tdata = {track_time, pos_z, pos_y, pos_x};

endmodule

// ===== rtl/core/kti_chk.sv =====
module kti_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  // stalled result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps its data
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result data changed while stalled");

  // a tick keeps the block busy after it is accepted
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("ready after tick transaction");

  // the block stays ready after a load
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> s_tready)
    else $error("not ready after load transaction");

endmodule

bind keyframe_track_interpolator kti_chk u_kti_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
